// File: sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, codes and register reset values for the button press
// classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // request codes
    localparam logic [1:0] REQ_EDGE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_POLL = 2'd2;

    // event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_CLICK = 2'd1;
    localparam logic [1:0] EV_LONG1 = 2'd2;
    localparam logic [1:0] EV_LONG2 = 2'd3;

    // duration classes
    localparam logic [1:0] DUR_NONE  = 2'd0;
    localparam logic [1:0] DUR_LONG1 = 2'd1;
    localparam logic [1:0] DUR_LONG2 = 2'd2;

    // register map, index = paddr[3:2]
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_LONG         = 2'd0;
    localparam logic [1:0] REG_VERY_LONG    = 2'd1;
    localparam logic [1:0] REG_LOCKOUT      = 2'd2;
    localparam logic [1:0] REG_RELEASE_STOP = 2'd3;

    localparam logic [7:0] RST_LONG         = 8'(3 * 20);
    localparam logic [7:0] RST_VERY_LONG    = 8'(6 * 20);
    localparam logic [7:0] RST_LOCKOUT      = 8'(7 * 20);
    localparam logic [7:0] RST_RELEASE_STOP = 8'd12;

    typedef struct packed {
        logic [7:0] long_ticks;
        logic [7:0] very_long_ticks;
        logic [7:0] lockout_ticks;
        logic [7:0] release_stop_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] req_type;
        logic       pin_level;
        logic       events_muted;
    } t_item;

    typedef struct packed {
        logic [1:0] event_code;
        logic       press_kind;
        logic [1:0] hold_class;
        logic       is_pressed;
        logic       timer_active;
    } t_result;

endpackage

// File: sv/bpc_in_if.sv
// ----------------------------------------------------------------------------
// bpc_in_if
// Input channel: valid/ready handshake carrying one request.
// ----------------------------------------------------------------------------
interface bpc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       pin_level;
    logic       events_muted;

    modport source (output valid, output req_type, output pin_level,
                    output events_muted, input ready);
    modport sink   (input valid, input req_type, input pin_level,
                    input events_muted, output ready);
endinterface

// File: sv/bpc_out_if.sv
// ----------------------------------------------------------------------------
// bpc_out_if
// Result channel: valid/ready handshake carrying one classification result.
// ----------------------------------------------------------------------------
interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       press_kind;
    logic [1:0] hold_class;
    logic       is_pressed;
    logic       timer_active;

    modport source (output valid, output event_code, output press_kind,
                    output hold_class, output is_pressed, output timer_active,
                    input ready);
    modport sink   (input valid, input event_code, input press_kind,
                    input hold_class, input is_pressed, input timer_active,
                    output ready);
endinterface

// File: sv/bpc_cfg.sv
// ----------------------------------------------------------------------------
// bpc_cfg
// APB register file holding the four tick thresholds.
// ----------------------------------------------------------------------------
module bpc_cfg
    import bpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_ticks         <= RST_LONG;
            r_cfg.very_long_ticks    <= RST_VERY_LONG;
            r_cfg.lockout_ticks      <= RST_LOCKOUT;
            r_cfg.release_stop_ticks <= RST_RELEASE_STOP;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LONG:         r_cfg.long_ticks         <= pwdata[7:0];
                REG_VERY_LONG:    r_cfg.very_long_ticks    <= pwdata[7:0];
                REG_LOCKOUT:      r_cfg.lockout_ticks      <= pwdata[7:0];
                REG_RELEASE_STOP: r_cfg.release_stop_ticks <= pwdata[7:0];
                default:          r_cfg                    <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LONG:         prdata = {24'd0, r_cfg.long_ticks};
            REG_VERY_LONG:    prdata = {24'd0, r_cfg.very_long_ticks};
            REG_LOCKOUT:      prdata = {24'd0, r_cfg.lockout_ticks};
            REG_RELEASE_STOP: prdata = {24'd0, r_cfg.release_stop_ticks};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/bpc_core.sv
// ----------------------------------------------------------------------------
// bpc_core
// Press state and its combinational next-state update for one registered request.
// ----------------------------------------------------------------------------
module bpc_core
    import bpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [7:0] r_hold_count, n_hold_count;
    logic [7:0] r_release_count, n_release_count;
    logic       r_timer_on, n_timer_on;
    logic       r_press_flag, n_press_flag;
    logic       r_key_kind, n_key_kind;
    logic [1:0] r_duration_class, n_duration_class;
    logic [1:0] n_event;
    logic [7:0] hold_inc;

    // saturating increment; a lockout of 255 lets the count reach the ceiling
    assign hold_inc = (r_hold_count == 8'hFF) ? r_hold_count : 8'(r_hold_count + 8'd1);

    always_comb begin
        n_hold_count     = r_hold_count;
        n_release_count  = r_release_count;
        n_timer_on       = r_timer_on;
        n_press_flag     = r_press_flag;
        n_key_kind       = r_key_kind;
        n_duration_class = r_duration_class;
        n_event          = EV_NONE;
        case (i_item.req_type)
            REQ_EDGE: begin
                if (!i_item.pin_level) begin
                    if (r_hold_count == 8'd0) begin
                        n_press_flag = 1'b1;
                        n_key_kind   = 1'b0;
                        n_timer_on   = 1'b1;
                    end
                end else begin
                    if (r_hold_count == 8'd0) begin
                        n_timer_on       = 1'b0;
                        n_duration_class = DUR_NONE;
                    end else if (r_hold_count < i_cfg.long_ticks) begin
                        n_timer_on       = 1'b0;
                        n_duration_class = DUR_NONE;
                        n_key_kind       = 1'b1;
                        n_hold_count     = 8'd0;
                        if (!i_item.events_muted) begin
                            n_event = EV_CLICK;
                        end
                    end else if (r_hold_count < i_cfg.lockout_ticks) begin
                        n_hold_count = 8'd0;
                    end
                    n_press_flag = 1'b0;
                end
            end
            REQ_TICK: begin
                if (r_timer_on) begin
                    if (!i_item.pin_level) begin
                        n_release_count = 8'd0;
                        if (r_hold_count <= i_cfg.lockout_ticks) begin
                            n_hold_count = hold_inc;
                            if (hold_inc == i_cfg.long_ticks) begin
                                n_duration_class = DUR_LONG1;
                                n_key_kind       = 1'b0;
                                n_event          = EV_LONG1;
                            end else if (hold_inc == i_cfg.very_long_ticks) begin
                                n_duration_class = DUR_LONG2;
                                n_key_kind       = 1'b0;
                                n_event          = EV_LONG2;
                            end
                        end
                    end else if (r_release_count >= i_cfg.release_stop_ticks) begin
                        n_release_count = 8'd0;
                        n_hold_count    = 8'd0;
                        n_timer_on      = 1'b0;
                    end else begin
                        n_release_count = 8'(r_release_count + 8'd1);
                    end
                end
            end
            REQ_POLL: begin
                if (i_item.pin_level && (r_hold_count >= i_cfg.lockout_ticks)) begin
                    n_hold_count = 8'd0;
                end
            end
            default: begin
                n_event = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count     <= 8'd0;
            r_release_count  <= 8'd0;
            r_timer_on       <= 1'b0;
            r_press_flag     <= 1'b0;
            r_key_kind       <= 1'b0;
            r_duration_class <= DUR_NONE;
        end else if (i_adv) begin
            r_hold_count     <= n_hold_count;
            r_release_count  <= n_release_count;
            r_timer_on       <= n_timer_on;
            r_press_flag     <= n_press_flag;
            r_key_kind       <= n_key_kind;
            r_duration_class <= n_duration_class;
        end
    end

    // result reflects the state after this transaction
    assign o_result.event_code   = n_event;
    assign o_result.press_kind   = n_key_kind;
    assign o_result.hold_class   = n_duration_class;
    assign o_result.is_pressed   = n_press_flag;
    assign o_result.timer_active = n_timer_on;

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_hold_count) && $stable(r_release_count) && $stable(r_timer_on))
        else $error("state changed without a transaction");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !r_timer_on && i_item.req_type == REQ_TICK)
        |=> $stable(r_hold_count) && $stable(r_release_count) && !r_timer_on)
        else $error("tick with stopped timer changed counters");

    a_click_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && n_event == EV_CLICK)
        |=> r_key_kind && !r_press_flag && !r_timer_on && r_hold_count == 8'd0)
        else $error("click left inconsistent state");

    a_long_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (n_event == EV_LONG1 || n_event == EV_LONG2))
        |=> r_timer_on && !r_key_kind && r_duration_class != DUR_NONE)
        else $error("long press left inconsistent state");

endmodule

// File: sv/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// Click / long-press classifier for one active-low button.
// ----------------------------------------------------------------------------
// Takes one request transaction (pin edge, timer tick or release poll) per
// clock and returns exactly one result transaction for each, in order.
// The request is captured in an input register, the press state is updated by
// one level of compare/increment logic, and the result lands in an output
// register. Throughput is one transaction per cycle; the input side keeps
// accepting while a result waits on the output, stalling only when both
// registers hold unconsumed data. Thresholds are set over APB (long, very
// long, lockout, release stop at 0x0/0x4/0x8/0xC) and should only be
// written while no transaction is in flight.
module button_press_classifier
    import bpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpc_in_if.sink            i_in,
    bpc_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result core_res;
    logic    adv;
    logic    in_take;

    bpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;
    assign in_take = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.req_type     <= i_in.req_type;
            r_in.pin_level    <= i_in.pin_level;
            r_in.events_muted <= i_in.events_muted;
        end
    end

    bpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_code   = r_out.event_code;
    assign o_out.press_kind   = r_out.press_kind;
    assign o_out.hold_class   = r_out.hold_class;
    assign o_out.is_pressed   = r_out.is_pressed;
    assign o_out.timer_active = r_out.timer_active;

endmodule

// File: bench/tb_button_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_classifier
// Self-checking bench for the click / long-press classifier.
// ----------------------------------------------------------------------------
// A short directed table covers the reset state, clicks, muted clicks,
// both long-press events, lockout, the release poll and the timer stop.
// A hold past 255 ticks shows the counter ceiling. Random press and
// release sequences mixed with noise then run under several threshold
// settings, including both extremes. Each result is checked against a
// local model of the press state or the table entry. The sender works in
// bursts; the receiver stalls in patterns, with one long output stall.
// ----------------------------------------------------------------------------
module tb_button_press_classifier;
    import bpc_pkg::*;

    localparam int unsigned CLK_HALF_NS     = 5;
    localparam int unsigned TIMEOUT_NS      = 2_000_000;
    localparam int unsigned DRAIN_CYCLES    = 6;
    localparam int unsigned HOLD_OFF_CYCLES = 60;
    localparam int unsigned PHASE_ITEMS     = 16;
    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned MAX_REPORTS     = 10;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic       KIND_NONE  = 1'b0;
    localparam logic       KIND_SHORT = 1'b1;

    typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} t_rx_mode;

    typedef struct {
        bit         is_cfg;
        logic [1:0] reg_idx;
        logic [7:0] value;
        t_item      it;
        bit         typed;
        t_result    want;
    } t_plan_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    bpc_in_if  in_ch ();
    bpc_out_if out_ch ();

    button_press_classifier uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the press state and thresholds
    t_cfg        thresholds;
    logic [7:0]  hold_cnt;
    logic [7:0]  release_cnt;
    logic        timer_run;
    logic        press_held;
    logic        key_short;
    logic [1:0]  dur_class;

    t_result     expected_results[$];
    t_plan_row   plan[$];

    int unsigned burst_left;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned settings_used;
    int unsigned hold_offs;
    bit          hold_off_req;

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_NS);
        $display("tb_button_press_classifier: FAIL");
        $finish;
    end

    // Updates the press state for one request and returns the result.
    function automatic t_result classify_press(t_item it);
        t_result r;
        logic [1:0] ev;
        ev = EV_NONE;
        case (it.req_type)
            REQ_EDGE: begin
                if (!it.pin_level) begin
                    if (hold_cnt == 8'd0) begin
                        press_held = 1'b1;
                        key_short  = KIND_NONE;
                        timer_run  = 1'b1;
                    end
                end else begin
                    if (hold_cnt == 8'd0) begin
                        timer_run = 1'b0;
                        dur_class = DUR_NONE;
                    end else if (hold_cnt < thresholds.long_ticks) begin
                        timer_run = 1'b0;
                        dur_class = DUR_NONE;
                        key_short = KIND_SHORT;
                        hold_cnt  = 8'd0;
                        if (!it.events_muted) ev = EV_CLICK;
                    end else if (hold_cnt < thresholds.lockout_ticks) begin
                        hold_cnt = 8'd0;
                    end
                    press_held = 1'b0;
                end
            end
            REQ_TICK: begin
                if (timer_run) begin
                    if (!it.pin_level) begin
                        release_cnt = 8'd0;
                        // counting stops one past the lockout value
                        if (hold_cnt <= thresholds.lockout_ticks) begin
                            if (hold_cnt != 8'hFF) hold_cnt = hold_cnt + 8'd1;
                            if (hold_cnt == thresholds.long_ticks) begin
                                dur_class = DUR_LONG1;
                                key_short = KIND_NONE;
                                ev = EV_LONG1;
                            end else if (hold_cnt == thresholds.very_long_ticks) begin
                                dur_class = DUR_LONG2;
                                key_short = KIND_NONE;
                                ev = EV_LONG2;
                            end
                        end
                    end else if (release_cnt >= thresholds.release_stop_ticks) begin
                        release_cnt = 8'd0;
                        hold_cnt    = 8'd0;
                        timer_run   = 1'b0;
                    end else begin
                        release_cnt = release_cnt + 8'd1;
                    end
                end
            end
            REQ_POLL: begin
                if (it.pin_level && hold_cnt >= thresholds.lockout_ticks) hold_cnt = 8'd0;
            end
            default: begin
            end
        endcase
        r.event_code   = ev;
        r.press_kind   = key_short;
        r.hold_class   = dur_class;
        r.is_pressed   = press_held;
        r.timer_active = timer_run;
        return r;
    endfunction

    function automatic void plan_item(logic [1:0] req, logic pin, logic muted);
        t_plan_row row;
        row = '{is_cfg: 1'b0, reg_idx: '0, value: '0, it: t_item'{req, pin, muted},
                typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_check(logic [1:0] req, logic pin, logic muted, t_result want);
        t_plan_row row;
        row = '{is_cfg: 1'b0, reg_idx: '0, value: '0, it: t_item'{req, pin, muted},
                typed: 1'b1, want: want};
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(logic [1:0] idx, logic [7:0] val);
        t_plan_row row;
        row = '{is_cfg: 1'b1, reg_idx: idx, value: val, it: '0, typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    // Offers one request transaction; the sender may idle between bursts.
    task automatic offer(input t_item it, input bit typed, input t_result want);
        t_result predicted;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid        <= 1'b1;
        in_ch.req_type     <= it.req_type;
        in_ch.pin_level    <= it.pin_level;
        in_ch.events_muted <= it.events_muted;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = classify_press(it);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
        burst_left--;
    endtask

    // Stops sending and waits until every result is back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LONG:         thresholds.long_ticks         = val;
            REG_VERY_LONG:    thresholds.very_long_ticks    = val;
            REG_LOCKOUT:      thresholds.lockout_ticks      = val;
            REG_RELEASE_STOP: thresholds.release_stop_ticks = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_thresholds(input logic [7:0] lng, input logic [7:0] vlng,
                                  input logic [7:0] lock, input logic [7:0] rstop);
        write_cfg(REG_LONG, lng);
        write_cfg(REG_VERY_LONG, vlng);
        write_cfg(REG_LOCKOUT, lock);
        write_cfg(REG_RELEASE_STOP, rstop);
        settings_used++;
    endtask

    // Receiver: ready follows a changing mode, with a long hold-off on request.
    initial begin
        t_rx_mode    rx_mode;
        int unsigned mode_left;
        logic [7:0]  rx_pattern;
        rx_mode    = RX_FREE;
        mode_left  = 0;
        rx_pattern = 8'hFF;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                hold_offs++;
            end else begin
                if (mode_left == 0) begin
                    rx_mode    = t_rx_mode'($urandom_range(0, 2));
                    rx_pattern = 8'($urandom_range(1, 255));
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:   out_ch.ready <= 1'b1;
                    RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        out_ch.ready <= rx_pattern[0];
                        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                    end
                endcase
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.event_code, out_ch.press_kind, out_ch.hold_class,
                    out_ch.is_pressed, out_ch.timer_active};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result ev=%0d kind=%0d hold=%0d pressed=%0d timer=%0d",
                             $time, got.event_code, got.press_kind, got.hold_class,
                             got.is_pressed, got.timer_active);
                end
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.event_code !== want.event_code || got.press_kind !== want.press_kind ||
                    got.hold_class !== want.hold_class || got.is_pressed !== want.is_pressed ||
                    got.timer_active !== want.timer_active) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: result %0d expected ev=%0d kind=%0d hold=%0d pressed=%0d timer=%0d",
                                 $time, results_checked, want.event_code, want.press_kind,
                                 want.hold_class, want.is_pressed, want.timer_active);
                        $display("%0t: result %0d actual   ev=%0d kind=%0d hold=%0d pressed=%0d timer=%0d",
                                 $time, results_checked, got.event_code, got.press_kind,
                                 got.hold_class, got.is_pressed, got.timer_active);
                    end
                end
            end
        end
    end

    initial begin
        t_item       episode[$];
        int unsigned phase;
        int unsigned phase_items;
        int unsigned hold_max;
        int unsigned rel_max;
        int unsigned n;
        int unsigned k;

        thresholds  = '{RST_LONG, RST_VERY_LONG, RST_LOCKOUT, RST_RELEASE_STOP};
        hold_cnt    = 8'd0;
        release_cnt = 8'd0;
        timer_run   = 1'b0;
        press_held  = 1'b0;
        key_short   = KIND_NONE;
        dur_class   = DUR_NONE;
        burst_left      = 0;
        items_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        settings_used   = 1;
        hold_offs       = 0;
        hold_off_req    = 1'b0;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.req_type     <= REQ_EDGE;
        in_ch.pin_level    <= 1'b1;
        in_ch.events_muted <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset thresholds first
        plan_check(REQ_TICK, 1'b0, 1'b0, '{EV_NONE, KIND_NONE, DUR_NONE, 1'b0, 1'b0});
        plan_check(REQ_UNUSED, 1'b1, 1'b1, '{EV_NONE, KIND_NONE, DUR_NONE, 1'b0, 1'b0});
        plan_check(REQ_EDGE, 1'b1, 1'b0, '{EV_NONE, KIND_NONE, DUR_NONE, 1'b0, 1'b0});
        plan_check(REQ_EDGE, 1'b0, 1'b0, '{EV_NONE, KIND_NONE, DUR_NONE, 1'b1, 1'b1});
        plan_item(REQ_TICK, 1'b0, 1'b1);
        plan_item(REQ_EDGE, 1'b0, 1'b0);      // press again with count running
        plan_check(REQ_EDGE, 1'b1, 1'b0, '{EV_CLICK, KIND_SHORT, DUR_NONE, 1'b0, 1'b0});
        plan_item(REQ_EDGE, 1'b0, 1'b1);
        plan_item(REQ_TICK, 1'b0, 1'b0);
        plan_check(REQ_EDGE, 1'b1, 1'b1, '{EV_NONE, KIND_SHORT, DUR_NONE, 1'b0, 1'b0});
        plan_cfg(REG_LONG, 8'd2);
        plan_cfg(REG_VERY_LONG, 8'd3);
        plan_cfg(REG_LOCKOUT, 8'd4);
        plan_cfg(REG_RELEASE_STOP, 8'd1);
        plan_item(REQ_EDGE, 1'b0, 1'b1);
        plan_item(REQ_TICK, 1'b0, 1'b0);
        plan_check(REQ_TICK, 1'b0, 1'b1, '{EV_LONG1, KIND_NONE, DUR_LONG1, 1'b1, 1'b1});
        plan_check(REQ_TICK, 1'b0, 1'b1, '{EV_LONG2, KIND_NONE, DUR_LONG2, 1'b1, 1'b1});
        plan_item(REQ_TICK, 1'b0, 1'b0);
        plan_item(REQ_TICK, 1'b0, 1'b0);
        plan_item(REQ_TICK, 1'b0, 1'b0);      // past lockout, count holds
        plan_item(REQ_EDGE, 1'b1, 1'b0);      // release in lockout keeps count
        plan_item(REQ_POLL, 1'b0, 1'b0);
        plan_item(REQ_POLL, 1'b1, 1'b1);
        plan_item(REQ_TICK, 1'b1, 1'b0);
        plan_item(REQ_TICK, 1'b1, 1'b0);      // release limit stops timer
        plan_item(REQ_EDGE, 1'b0, 1'b0);
        plan_item(REQ_TICK, 1'b0, 1'b0);
        plan_item(REQ_TICK, 1'b0, 1'b0);
        plan_item(REQ_EDGE, 1'b1, 1'b0);      // release after long press, no click
        plan_item(REQ_TICK, 1'b1, 1'b1);
        plan_item(REQ_TICK, 1'b1, 1'b1);

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                write_cfg(plan[r].reg_idx, plan[r].value);
            end else begin
                offer(plan[r].it, plan[r].typed, plan[r].want);
            end
        end
        settings_used++;

        // hold past 255 ticks with lockout at 255: count must saturate
        set_thresholds(8'd250, 8'd253, 8'd255, 8'd0);
        offer(t_item'{REQ_EDGE, 1'b0, 1'($urandom)}, 1'b0, '0);
        repeat (258) offer(t_item'{REQ_TICK, 1'b0, 1'($urandom)}, 1'b0, '0);
        offer(t_item'{REQ_EDGE, 1'b1, 1'b0}, 1'b0, '0);
        offer(t_item'{REQ_POLL, 1'b1, 1'($urandom)}, 1'b0, '0);
        offer(t_item'{REQ_TICK, 1'b1, 1'($urandom)}, 1'b0, '0);

        // random press sequences under several settings
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: set_thresholds(8'd1, 8'd1, 8'd1, 8'd0);
                3: set_thresholds(8'd255, 8'd255, 8'd254, 8'd255);
                4: set_thresholds(8'd0, 8'd0, 8'd0, 8'd0);
                default: set_thresholds(8'($urandom_range(1, 6)), 8'($urandom_range(1, 10)),
                                        8'($urandom_range(1, 12)), 8'($urandom_range(0, 4)));
            endcase
            if (phase == 2) hold_off_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                episode.delete();
                if ($urandom_range(0, 4) != 0) begin
                    hold_max = (thresholds.lockout_ticks > 8'd20) ? 24 :
                               int'(thresholds.lockout_ticks) + 3;
                    rel_max  = (thresholds.release_stop_ticks > 8'd8) ? 10 :
                               int'(thresholds.release_stop_ticks) + 2;
                    episode.push_back(t_item'{REQ_EDGE, 1'b0, 1'($urandom)});
                    n = $urandom_range(0, hold_max);
                    for (k = 0; k < n; k++) begin
                        if ($urandom_range(0, 7) == 0) begin
                            episode.push_back(t_item'{($urandom_range(0, 1) != 0) ? REQ_POLL
                                                      : REQ_EDGE, 1'b0, 1'($urandom)});
                        end
                        episode.push_back(t_item'{REQ_TICK, 1'b0, 1'($urandom)});
                    end
                    // now and then the release edge goes missing
                    if ($urandom_range(0, 9) != 0) begin
                        episode.push_back(t_item'{REQ_EDGE, 1'b1, 1'($urandom)});
                    end
                    n = $urandom_range(0, rel_max);
                    for (k = 0; k < n; k++) begin
                        episode.push_back(t_item'{REQ_TICK, 1'b1, 1'($urandom)});
                    end
                    if ($urandom_range(0, 1) != 0) begin
                        episode.push_back(t_item'{REQ_POLL, 1'b1, 1'($urandom)});
                    end
                end else begin
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++) episode.push_back(t_item'(4'($urandom)));
                end
                foreach (episode[j]) offer(episode[j], 1'b0, '0);
                phase_items += episode.size();
            end
        end

        wait_drained();
        $display("tb_button_press_classifier: %0d requests, %0d results checked, %0d mismatches",
                 items_sent, results_checked, mismatches);
        $display("tb_button_press_classifier: %0d threshold settings, %0d long output stalls",
                 settings_used, hold_offs);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_button_press_classifier: PASS");
        end else begin
            $display("tb_button_press_classifier: FAIL");
        end
        $finish;
    end

endmodule
